### rtl/core/lcaa_pkg.sv
`timescale 1ns / 1ps
package lcaa_pkg;

  // field and datapath widths
  localparam int PpgW    = 12;
  localparam int CurW    = 13;
  localparam int StepW   = 21;
  localparam int ProdW   = 26;
  localparam int FactW   = 5;
  localparam int DivW    = 13;
  localparam int WordW   = 16;
  localparam int StepFW  = 14;
  localparam int HeartW  = 7;
  localparam int OffW    = 14;
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 2;
  localparam int CntW    = 5;

  // constants of the adjustment loop
  localparam int StepReset  = 307200;
  localparam int StepMax    = 1536000;
  localparam int StepMin    = 15360;
  localparam int WordMin    = 2;
  localparam int WordMax    = 1000;
  localparam int FactorUp   = 22;
  localparam int FactorDown = 11;
  localparam int FactorOne  = 16;
  localparam int CurBias    = 20;
  localparam int HeadroomUp = 3072;
  localparam int HeadroomDn = 1024;
  localparam int TraceMax   = 511;

  localparam int PpgHighReset = 3900;
  localparam int PpgLowReset  = 200;
  localparam int CurHighReset = 1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PPG_HIGH = 2'd0,
    CFG_PPG_LOW  = 2'd1,
    CFG_CUR_HIGH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCALE = 2'd1,
    ST_DIV   = 2'd2,
    ST_DONE  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic             ppg_ok;
    logic [PpgW-1:0]  ppg_sample;
    logic [PpgW-1:0]  led_current;
  } in_item_t;

  typedef struct packed {
    logic              adjust_write;
    logic [WordW-1:0]  adjust_word;
    logic [HeartW-1:0] heart_sample;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic do_adj;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/lcaa_chan_if.sv
`timescale 1ns / 1ps
interface lcaa_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/lcaa_div.sv
`timescale 1ns / 1ps
module lcaa_div
  import lcaa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [StepW-1:0] dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             done_o,
  output logic [StepW-1:0] quotient_o
);

  logic [StepW-1:0] quo_q, quo_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivW:0]    rem_sh;
  logic             fits;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[StepW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DivW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivW-1:0];
      quo_d = {quo_q[StepW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(StepW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/lcaa_dp.sv
`timescale 1ns / 1ps
module lcaa_dp
  import lcaa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  in_item_t           in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output out_item_t          out_data_o
);

  logic [PpgW-1:0]  ppg_high_q, ppg_low_q, cur_high_q;
  logic             ok_q;
  logic [PpgW-1:0]  ppg_q;
  logic [CurW-1:0]  cur_q;
  logic [StepW-1:0] step_q;
  dir_e             dir_last_q, dir_before_q;
  logic [PpgW-1:0]  prev_ppg_q;
  logic             prev_adj_q;
  logic signed [OffW-1:0] offset_q, offset_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  logic             up_hit, dn_hit, cur_ok, do_adj;
  dir_e             rev_dir, same_dir, dir_new;
  logic [FactW-1:0] factor;
  logic [ProdW-1:0] prod;
  logic [ProdW-5:0] scaled;
  logic [StepW-1:0] step_clamp;
  logic [DivW-1:0]  divisor;
  logic             div_done;
  logic [StepW-1:0] quotient;
  logic [StepFW-1:0] step_field;
  logic signed [OffW:0]   diff, tmp;
  logic signed [OffW+1:0] value;
  logic [8:0]       trace;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppg_high_q <= CfgW'(PpgHighReset);
      ppg_low_q  <= CfgW'(PpgLowReset);
      cur_high_q <= CfgW'(CurHighReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PPG_HIGH: ppg_high_q <= cfg_data_i;
        CFG_PPG_LOW:  ppg_low_q  <= cfg_data_i;
        CFG_CUR_HIGH: cur_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ok_q  <= in_data_i.ppg_ok;
      ppg_q <= in_data_i.ppg_sample;
      cur_q <= {1'b0, in_data_i.led_current} + CurW'(CurBias);
    end
  end

  // classification of the held sample; high limit wins when both are crossed
  always_comb begin
    up_hit   = ok_q && (ppg_q > ppg_high_q);
    dn_hit   = ok_q && !up_hit && (ppg_q < ppg_low_q);
    cur_ok   = cur_q < {1'b0, cur_high_q};
    do_adj   = dn_hit || (up_hit && cur_ok);
    rev_dir  = up_hit ? DIR_DOWN : DIR_UP;
    same_dir = up_hit ? DIR_UP : DIR_DOWN;
    dir_new  = up_hit ? DIR_UP : (dn_hit ? DIR_DOWN : DIR_NONE);
  end

  // step scaling in q4
  always_comb begin
    if (dir_last_q == rev_dir) begin
      factor = FactW'(FactorDown);
    end else if (dir_last_q == same_dir && dir_before_q == same_dir) begin
      factor = FactW'(FactorUp);
    end else begin
      factor = FactW'(FactorOne);
    end
    prod   = ProdW'(step_q) * ProdW'(factor);
    scaled = prod[ProdW-1:4];
    if (scaled > (ProdW-4)'(StepMax)) begin
      step_clamp = StepW'(StepMax);
    end else if (scaled < (ProdW-4)'(StepMin)) begin
      step_clamp = StepW'(StepMin);
    end else begin
      step_clamp = scaled[StepW-1:0];
    end
    if (up_hit) begin
      divisor = (cur_q < DivW'(HeadroomUp)) ? DivW'(HeadroomUp) - cur_q : DivW'(1);
    end else begin
      divisor = DivW'(HeadroomDn) + cur_q;
    end
  end

  lcaa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.scale),
    .dividend_i (step_clamp),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (quotient <= StepW'(WordMin)) begin
      step_field = StepFW'(WordMin);
    end else if (quotient >= StepW'(WordMax)) begin
      step_field = StepFW'(WordMax);
    end else begin
      step_field = quotient[StepFW-1:0];
    end
  end

  // offset removes the jump that follows an adjustment
  always_comb begin
    diff = prev_adj_q ? (OffW+1)'($signed({1'b0, prev_ppg_q}) - $signed({1'b0, ppg_q}))
                      : '0;
    tmp  = (OffW+1)'(offset_q) + diff;
    value = (OffW+2)'(tmp) + $signed((OffW+2)'({1'b0, ppg_q}));
    if (value > (OffW+2)'(TraceMax)) begin
      offset_d = OffW'((OffW+2)'(TraceMax) - $signed((OffW+2)'({1'b0, ppg_q})));
      trace    = 9'(TraceMax);
    end else if (value < 0) begin
      offset_d = OffW'(-$signed((OffW+2)'({1'b0, ppg_q})));
      trace    = '0;
    end else begin
      offset_d = OffW'(tmp);
      trace    = value[8:0];
    end
    out_d.adjust_write = do_adj;
    out_d.adjust_word  = do_adj ? {1'b1, up_hit, step_field} : '0;
    out_d.heart_sample = trace[8:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= StepW'(StepReset);
      dir_last_q   <= DIR_NONE;
      dir_before_q <= DIR_NONE;
      prev_ppg_q   <= '0;
      prev_adj_q   <= 1'b0;
      offset_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.scale) begin
        step_q <= step_clamp;
      end
      if (cmd_i.commit) begin
        if (ok_q) begin
          dir_before_q <= dir_last_q;
          dir_last_q   <= dir_new;
        end
        prev_ppg_q <= ppg_q;
        prev_adj_q <= do_adj;
        offset_q   <= offset_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign sts_o.do_adj   = do_adj;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q >= StepW'(StepMin) && step_q <= StepW'(StepMax))
    else $error("adaptive step outside its clamp range");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q >= -14'sd4095 && offset_q <= 14'sd511)
    else $error("trace offset outside its settled range");

  a_word_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.adjust_write |->
      out_q.adjust_word[15] && out_q.adjust_word[StepFW-1:0] >= StepFW'(WordMin) &&
      out_q.adjust_word[StepFW-1:0] <= StepFW'(WordMax))
    else $error("issued adjust word malformed");

  a_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.adjust_write |-> out_q.adjust_word == '0)
    else $error("adjust word set without a write");

  a_scale_needs_adj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |-> do_adj)
    else $error("step scaled for a sample that causes no adjustment");

endmodule

### rtl/core/lcaa_ctrl.sv
`timescale 1ns / 1ps
module lcaa_ctrl
  import lcaa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (sts_i.do_adj) begin
          cmd_o.scale = 1'b1;
          state_d     = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait here while the previous word still sits in the output register
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("sample accepted while one is in flight");

  a_commit_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !cmd_o.commit)
    else $error("commit straight after load");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scale |=> state_q == ST_DIV && !sts_i.div_done)
    else $error("divider finished too early");

endmodule

### rtl/core/led_current_auto_adjust_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake            | word
// ----------+-----+----------------------+--------------------------------------------
// sample_i  | in  | valid/ready          | ppg_ok, ppg_sample, led_current
// result_o  | out | valid/ready          | adjust_write, adjust_word, heart_sample
// cfg       | in  | cfg_we_i, no stall   | cfg_idx_i, cfg_data_i (12 bit limits)
//
// a sample that triggers an adjustment reaches the result register after its step is
// scaled, the restoring divider (one quotient bit a cycle) has run, and control commits
// it; any other sample skips the scaling and the divider.
// one sample is worked on at a time; the next is taken in the cycle after the result
// is loaded, while that result may still wait for the sink.
// a stalled sink holds the finished sample in its last state until the register frees.
// reset (rst_ni, asynchronous) restores the limits and the loop state at once.
module led_current_auto_adjust_core
  import lcaa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  lcaa_chan_if.sink          sample_i,
  lcaa_chan_if.source        result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_item_t  in_data;
  out_item_t out_data;

  assign in_data = in_item_t'(sample_i.data);

  lcaa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcaa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (out_data)
  );

  assign result_o.data = out_data;

endmodule

### tb/lcaa_adjust_checker.sv
`timescale 1ns / 1ps
module lcaa_adjust_checker
  import lcaa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_valid_i,
  input  logic               sample_ready_i,
  input  in_item_t           sample_data_i,
  input  logic               result_valid_i,
  input  logic               result_ready_i,
  input  out_item_t          result_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [CfgW-1:0]        ppg_high;
  logic [CfgW-1:0]        ppg_low;
  logic [CfgW-1:0]        cur_high;
  logic [StepW-1:0]       step_q;
  dir_e                   dir_last;
  dir_e                   dir_prev;
  logic [PpgW-1:0]        last_ppg;
  logic                   last_adjusted;
  logic signed [OffW-1:0] trace_offset;
  out_item_t              adjust_out_q[$];
  int                     fail_cnt;

  assign fail_count_o = fail_cnt;

  // scale the step in q4, clamp it, and turn it into a current step for the divisor
  function automatic logic [StepFW-1:0] scale_step(dir_e reverse, dir_e same, int divisor);
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] quot;
    if (dir_last == reverse) begin
      prod = ProdW'(step_q) * ProdW'(FactorDown);
    end else if (dir_last == same && dir_prev == same) begin
      prod = ProdW'(step_q) * ProdW'(FactorUp);
    end else begin
      prod = ProdW'(step_q) * ProdW'(FactorOne);
    end
    prod = prod >> 4;
    if (prod > StepMax) prod = ProdW'(StepMax);
    if (prod < StepMin) prod = ProdW'(StepMin);
    step_q = StepW'(prod);
    if (divisor < 1) divisor = 1;
    quot = prod / ProdW'(divisor);
    if (quot < WordMin) quot = ProdW'(WordMin);
    if (quot > WordMax) quot = ProdW'(WordMax);
    return StepFW'(quot);
  endfunction

  function automatic out_item_t predict_sample(in_item_t s);
    logic [CurW-1:0] cur;
    int              div;
    int              off;
    int              value;
    out_item_t       r;
    r   = '0;
    cur = CurW'(s.led_current) + CurW'(CurBias);
    if (s.ppg_ok) begin
      if (s.ppg_sample > ppg_high) begin
        // blocked by current: no word, but the move still counts as up
        if (cur < cur_high) begin
          div = (cur < HeadroomUp) ? HeadroomUp - int'(cur) : 1;
          r.adjust_word  = {2'b11, scale_step(DIR_DOWN, DIR_UP, div)};
          r.adjust_write = 1'b1;
        end
        dir_prev = dir_last;
        dir_last = DIR_UP;
      end else if (s.ppg_sample < ppg_low) begin
        r.adjust_word  = {2'b10, scale_step(DIR_UP, DIR_DOWN, HeadroomDn + int'(cur))};
        r.adjust_write = 1'b1;
        dir_prev = dir_last;
        dir_last = DIR_DOWN;
      end else begin
        dir_prev = dir_last;
        dir_last = DIR_NONE;
      end
    end
    // cancel the step in the trace after an adjustment
    off = int'(trace_offset);
    if (last_adjusted) off = off + int'(last_ppg) - int'(s.ppg_sample);
    value = int'(s.ppg_sample) + off;
    if (value > TraceMax) begin
      off   = off - (value - TraceMax);
      value = TraceMax;
    end else if (value < 0) begin
      off   = off - value;
      value = 0;
    end
    trace_offset   = OffW'(off);
    last_ppg       = s.ppg_sample;
    last_adjusted  = r.adjust_write;
    r.heart_sample = HeartW'(value >> 2);
    return r;
  endfunction

  function automatic void check_field(string name, logic [WordW-1:0] want_v,
                                      logic [WordW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected %0h got %0h", name, want_v, got_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      ppg_high      = CfgW'(PpgHighReset);
      ppg_low       = CfgW'(PpgLowReset);
      cur_high      = CfgW'(CurHighReset);
      step_q        = StepW'(StepReset);
      dir_last      = DIR_NONE;
      dir_prev      = DIR_NONE;
      last_ppg      = '0;
      last_adjusted = 1'b0;
      trace_offset  = '0;
      adjust_out_q.delete();
      fail_cnt      = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PPG_HIGH: ppg_high = cfg_data_i;
          CFG_PPG_LOW:  ppg_low  = cfg_data_i;
          CFG_CUR_HIGH: cur_high = cfg_data_i;
          default: ;
        endcase
      end
      if (result_valid_i && result_ready_i) begin
        if (adjust_out_q.size() == 0) begin
          $error("result word with no sample waiting");
          fail_cnt++;
        end else begin
          want = adjust_out_q.pop_front();
          check_field("adjust_write", WordW'(want.adjust_write),
                      WordW'(result_data_i.adjust_write));
          check_field("adjust_word", want.adjust_word, result_data_i.adjust_word);
          check_field("heart_sample", WordW'(want.heart_sample),
                      WordW'(result_data_i.heart_sample));
        end
      end
      if (sample_valid_i && sample_ready_i) begin
        adjust_out_q.push_back(predict_sample(sample_data_i));
      end
      pending_o <= adjust_out_q.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lcaa_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int TailCycles    = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  int send_idle;
  int recv_idle;
  int idle_cycles = 0;
  int mismatch_count;
  int results_due;
  int ppg_hi;
  int ppg_lo;
  int cur_hi;
  int run_left;
  int run_kind;

  lcaa_chan_if #(.T(in_item_t))  sample_if ();
  lcaa_chan_if #(.T(out_item_t)) result_if ();

  led_current_auto_adjust_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  lcaa_adjust_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_if.valid),
    .sample_ready_i (sample_if.ready),
    .sample_data_i  (sample_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_data_i  (result_if.data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (mismatch_count),
    .pending_o      (results_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ends the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_sample(input logic ok, input int ppg, input int cur);
    in_item_t s;
    s.ppg_ok      = ok;
    s.ppg_sample  = PpgW'(ppg);
    s.led_current = PpgW'(cur);
    while ($urandom_range(99) < send_idle) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_limits(input int hi, input int lo, input int ch);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PPG_HIGH;
    cfg_data <= CfgW'(hi);
    @(posedge clk);
    cfg_idx  <= CFG_PPG_LOW;
    cfg_data <= CfgW'(lo);
    @(posedge clk);
    cfg_idx  <= CFG_CUR_HIGH;
    cfg_data <= CfgW'(ch);
    @(posedge clk);
    cfg_we   <= 1'b0;
    ppg_hi = hi;
    ppg_lo = lo;
    cur_hi = ch;
  endtask

  // runs of the same kind so that repeated moves and reversals both occur
  task automatic random_sample();
    logic ok;
    int   ppg;
    int   cur;
    int   pick;
    if (run_left == 0) begin
      pick     = $urandom_range(9);
      run_kind = (pick < 4) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
      run_left = $urandom_range(6, 1);
    end
    run_left--;
    ok = ($urandom_range(15) != 0);
    case (run_kind)
      0: ppg = (ppg_hi < 4095) ? $urandom_range(4095, ppg_hi + 1) : 4095;
      1: ppg = (ppg_lo > 0) ? $urandom_range(ppg_lo - 1, 0) : 0;
      2: ppg = (ppg_lo <= ppg_hi) ? $urandom_range(ppg_hi, ppg_lo) : $urandom_range(4095);
      default: ppg = $urandom_range(4095);
    endcase
    cur = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(cur_hi);
    send_sample(ok, ppg, cur);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      random_sample();
      if ($urandom_range(63) == 0) drain();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.data  <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_PPG_HIGH;
    cfg_data        <= '0;
    send_idle = 13;
    recv_idle = 71;
    ppg_hi    = PpgHighReset;
    ppg_lo    = PpgLowReset;
    cur_hi    = CurHighReset;
    run_left  = 0;
    run_kind  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // invalid samples at the extremes
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, 4095, 4095);
    // upward moves, the third one grows the step
    send_sample(1'b1, 4095, 0);
    send_sample(1'b1, 4000, 100);
    send_sample(1'b1, 3901, 500);
    send_sample(1'b1, 4095, 979);
    // current too high for an upward move
    send_sample(1'b1, 4095, 980);
    // reversal, then downward moves, one of them at full current
    send_sample(1'b1, 0, 0);
    send_sample(1'b1, 199, 4095);
    send_sample(1'b1, 100, 2000);
    // on the limits counts as inside
    send_sample(1'b1, 200, 0);
    send_sample(1'b1, 3900, 0);
    send_sample(1'b1, 0, 0);
    // alternating directions shrink the step
    send_sample(1'b1, 4095, 0);
    send_sample(1'b1, 0, 4095);
    send_sample(1'b1, 4095, 0);
    send_sample(1'b1, 300, 0);
    send_sample(1'b1, 511, 0);
    // high limit below low limit: the upward branch wins
    write_limits(100, 3000, 3071);
    send_sample(1'b1, 2000, 3050);
    send_sample(1'b1, 50, 0);
    send_sample(1'b1, 4095, 3051);
    write_limits(4095, 0, 0);
    send_sample(1'b1, 4095, 0);
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 2048, 2048);

    write_limits(3900, 200, 1000);
    run_random(210);
    write_limits(3000, 600, 3071);
    run_random(210);
    send_idle = 71;
    recv_idle = 13;
    write_limits(2048, 2047, 1500);
    run_random(210);
    write_limits(0, 4095, 2000);
    run_random(210);
    send_idle = 0;
    recv_idle = 0;
    write_limits($urandom_range(4095), $urandom_range(4095), $urandom_range(3071));
    run_random(210);
    write_limits(3500, 1000, 3071);
    run_random(200);

    drain();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
